/* rtl/dwhg_pkg.sv */
// Shared types and constants for the double-word half-GCD matrix unit.
// No dependencies.
package dwhg_pkg;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_FIRST,
    ST_RED_SUB,
    ST_RED_CHK,
    ST_DIV_NORM,
    ST_DIV_STEP,
    ST_DIV_DONE,
    ST_MUL_LO,
    ST_MUL_MID,
    ST_MUL,
    ST_OUT
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_SUB,
    OP_ADD1,
    OP_DIV_INIT,
    OP_DIV_NORM,
    OP_DIV_STEP,
    OP_Q_INC,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_MUL_MID,
    OP_TOGGLE,
    OP_FAIL
  } op_t;

  // Controller to datapath
  typedef struct packed {
    op_t  op;
    logic side_b;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_small;
    logic first_small;
    logic skip_a;
    logic hi_equal;
    logic x_small;
    logic x_le_y;
    logic d_norm;
    logic div_last;
  } stat_t;

endpackage

/* rtl/double_word_half_gcd_matrix_unit.sv */
// Channel | dir | handshake      | payload
// in      | in  | in_valid/stall | a_high a_low b_high b_low
// out     | out | out_valid/stall| progress m00 m01 m10 m11
// One request at a time; after acceptance come the start checks, then per
// Euclid step a single subtraction or a division made of the normalise shifts,
// the one-bit-per-cycle divider and the three-pass multiply; then the closing
// check, and the result stays in the result slot until taken.
// Reset (rst, synchronous) returns to idle.
// in_stall is high while a request is in flight; out stall holds the result.
// Depends on dwhg_pkg, dwhg_ctrl and dwhg_dp.
module double_word_half_gcd_matrix_unit #(
  parameter int LIMB_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] a_high,
  input  logic [63:0] a_low,
  input  logic [63:0] b_high,
  input  logic [63:0] b_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        progress,
  output logic [63:0] m00,
  output logic [63:0] m01,
  output logic [63:0] m10,
  output logic [63:0] m11
);
  import dwhg_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  busy, done;

  assign in_stall  = busy;
  assign out_valid = done;

  // Controller
  dwhg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && !busy), .out_free(!out_stall),
    .st(st), .cmd(cmd), .busy(busy), .done(done)
  );

  // Datapath
  dwhg_dp #(.LIMB_BITS(LIMB_BITS)) u_dp (
    .clk(clk), .a_high(a_high), .a_low(a_low), .b_high(b_high), .b_low(b_low),
    .cmd(cmd), .st(st), .progress(progress),
    .m00(m00), .m01(m01), .m10(m10), .m11(m11)
  );

endmodule

/* rtl/dwhg_ctrl.sv */
// Controller state machine for the double-word half-GCD matrix unit.
// Depends on dwhg_pkg.
module dwhg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_free,
  input  dwhg_pkg::stat_t st,
  output dwhg_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import dwhg_pkg::*;

  state_t state, state_next;
  logic   side_b, side_b_next;
  logic   stop_after, stop_after_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      side_b     <= 1'b0;
      stop_after <= 1'b0;
    end else begin
      state      <= state_next;
      side_b     <= side_b_next;
      stop_after <= stop_after_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    side_b_next     = side_b;
    stop_after_next = stop_after;
    cmd.op          = OP_NONE;
    cmd.side_b      = side_b;
    busy            = 1'b1;
    done            = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.op     = OP_LOAD;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (st.start_small) begin
          cmd.op     = OP_FAIL;
          state_next = ST_OUT;
        end else begin
          cmd.op     = OP_FIRST;
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (st.first_small) begin
          cmd.op     = OP_FAIL;
          state_next = ST_OUT;
        end else begin
          side_b_next = !st.skip_a ? 1'b0 : 1'b1;
          state_next  = ST_RED_SUB;
        end
      end
      ST_RED_SUB: begin
        if (st.hi_equal) begin
          state_next = ST_OUT;
        end else begin
          cmd.op     = OP_SUB;
          state_next = ST_RED_CHK;
        end
      end
      ST_RED_CHK: begin
        if (st.x_small) begin
          state_next = ST_OUT;
        end else if (st.x_le_y) begin
          cmd.op      = OP_ADD1;
          side_b_next = !side_b;
          state_next  = ST_RED_SUB;
        end else begin
          cmd.op     = OP_DIV_INIT;
          state_next = ST_DIV_NORM;
        end
      end
      ST_DIV_NORM: begin
        if (st.d_norm) begin
          state_next = ST_DIV_STEP;
        end else begin
          cmd.op = OP_DIV_NORM;
        end
      end
      ST_DIV_STEP: begin
        cmd.op = OP_DIV_STEP;
        if (st.div_last) begin
          state_next = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: begin
        stop_after_next = st.x_small;
        if (!st.x_small) begin
          cmd.op = OP_Q_INC;
        end
        state_next = ST_MUL_LO;
      end
      // Multiply the quotient into the column over three half-width passes
      ST_MUL_LO: begin
        cmd.op     = OP_MUL_LO;
        state_next = ST_MUL_MID;
      end
      ST_MUL_MID: begin
        cmd.op     = OP_MUL_MID;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op      = OP_MUL_HI;
        side_b_next = !side_b;
        state_next  = stop_after ? ST_OUT : ST_RED_SUB;
      end
      ST_OUT: begin
        done = 1'b1;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Division steps start once the divisor is normalised
  a_step_norm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_NORM && st.d_norm) |=> (state == ST_DIV_STEP))
    else $error("division step not started after normalising");
  // Every request leaves idle for the start check
  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_fire) |=> (state == ST_START))
    else $error("request not loaded");
  // Result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_free) |=> (state == ST_OUT))
    else $error("result dropped");
`endif

endmodule

/* rtl/dwhg_dp.sv */
// Datapath for the double-word half-GCD matrix unit: operands, divider and matrix.
// Depends on dwhg_pkg.
module dwhg_dp #(
  parameter int LIMB_BITS = 64
) (
  input  logic                 clk,
  input  logic [63:0]          a_high,
  input  logic [63:0]          a_low,
  input  logic [63:0]          b_high,
  input  logic [63:0]          b_low,
  input  dwhg_pkg::cmd_t       cmd,
  output dwhg_pkg::stat_t      st,
  output logic                 progress,
  output logic [63:0]          m00,
  output logic [63:0]          m01,
  output logic [63:0]          m10,
  output logic [63:0]          m11
);
  import dwhg_pkg::*;

  localparam int L  = LIMB_BITS;
  localparam int DW = 2 * LIMB_BITS;
  localparam int HL = (LIMB_BITS + 1) / 2;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] a, b, d;
  logic [L-1:0]  u00, u01, u10, u11, q;
  logic [CW-1:0] cnt;
  logic          prog;
  logic          first_a;

  // Selected working operands: x is reduced by y
  logic [DW-1:0] x, y, x_sub, n_sub;
  logic [L-1:0]  x_hi, y_hi, s, t, p, r;
  logic          n_ge;

  assign x    = cmd.side_b ? b : a;
  assign y    = cmd.side_b ? a : b;
  assign x_hi = x[DW-1:L];
  assign y_hi = y[DW-1:L];
  assign s    = cmd.side_b ? u01 : u00;
  assign t    = cmd.side_b ? u11 : u10;
  assign p    = cmd.side_b ? u00 : u01;
  assign r    = cmd.side_b ? u10 : u11;
  assign x_sub = x - y;
  assign n_ge  = (x >= d);
  assign n_sub = x - d;

  // Half-width multiplier: q times the column entries, low L bits only
  logic [HL-1:0]   q_l, q_h, s_l, s_h, t_l, t_h, mul_q, mul_s, mul_t;
  logic [2*HL-1:0] prod_s, prod_t;
  logic [L-1:0]    sh_s, sh_t, acc_p, acc_r;
  assign q_l    = q[HL-1:0];
  assign q_h    = HL'(q >> HL);
  assign s_l    = s[HL-1:0];
  assign s_h    = HL'(s >> HL);
  assign t_l    = t[HL-1:0];
  assign t_h    = HL'(t >> HL);
  assign mul_q  = (cmd.op == OP_MUL_HI) ? q_h : q_l;
  assign mul_s  = (cmd.op == OP_MUL_MID) ? s_h : s_l;
  assign mul_t  = (cmd.op == OP_MUL_MID) ? t_h : t_l;
  assign prod_s = mul_q * mul_s;
  assign prod_t = mul_q * mul_t;
  assign sh_s   = L'({prod_s, {HL{1'b0}}});
  assign sh_t   = L'({prod_t, {HL{1'b0}}});

  // Status back to the controller
  logic a_gt_b;
  assign a_gt_b          = (a > b);
  assign st.start_small  = (a[DW-1:L] < L'(2)) || (b[DW-1:L] < L'(2));
  assign st.first_small  = first_a ? (a[DW-1:L] < L'(2)) : (b[DW-1:L] < L'(2));
  assign st.skip_a       = (a[DW-1:L] < b[DW-1:L]);
  assign st.hi_equal     = (x_hi == y_hi);
  assign st.x_small      = (x_hi < L'(2));
  assign st.x_le_y       = (x_hi <= y_hi);
  assign st.d_norm       = d[DW-1];
  assign st.div_last     = (cnt == '0);

  // Operand, divider and matrix registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a    <= {a_high[L-1:0], a_low[L-1:0]};
        b    <= {b_high[L-1:0], b_low[L-1:0]};
        prog <= 1'b1;
      end
      OP_FIRST: begin
        first_a <= a_gt_b;
        if (a_gt_b) begin
          a <= a - b;
          u00 <= L'(1); u01 <= L'(1); u11 <= L'(1); u10 <= '0;
        end else begin
          b <= b - a;
          u00 <= L'(1); u10 <= L'(1); u11 <= L'(1); u01 <= '0;
        end
      end
      OP_SUB: begin
        if (cmd.side_b) b <= x_sub; else a <= x_sub;
      end
      OP_ADD1: begin
        if (cmd.side_b) begin
          u00 <= u00 + u01; u10 <= u10 + u11;
        end else begin
          u01 <= u01 + u00; u11 <= u11 + u10;
        end
      end
      OP_DIV_INIT: begin
        d   <= y;
        q   <= '0;
        cnt <= '0;
      end
      OP_DIV_NORM: begin
        d   <= d << 1;
        cnt <= cnt + CW'(1);
      end
      OP_DIV_STEP: begin
        q <= {q[L-2:0], n_ge};
        if (n_ge) begin
          if (cmd.side_b) b <= n_sub; else a <= n_sub;
        end
        d   <= d >> 1;
        cnt <= cnt - CW'(1);
      end
      OP_Q_INC: begin
        q <= q + L'(1);
      end
      OP_MUL_LO: begin
        acc_p <= L'(prod_s);
        acc_r <= L'(prod_t);
      end
      OP_MUL_MID: begin
        acc_p <= acc_p + sh_s;
        acc_r <= acc_r + sh_t;
      end
      OP_MUL_HI: begin
        if (cmd.side_b) begin
          u00 <= p + acc_p + sh_s; u10 <= r + acc_r + sh_t;
        end else begin
          u01 <= p + acc_p + sh_s; u11 <= r + acc_r + sh_t;
        end
      end
      OP_FAIL: begin
        prog <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result fields, zero when no progress
  assign progress = prog;
  assign m00 = prog ? 64'(u00) : '0;
  assign m01 = prog ? 64'(u01) : '0;
  assign m10 = prog ? 64'(u10) : '0;
  assign m11 = prog ? 64'(u11) : '0;

endmodule
